/* hw/rtl/assert_macros.svh */
// assertion helpers for wim_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("check failed");

`define CHK_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("check failed");

`endif

/* hw/rtl/wim_pkg.sv */
package wim_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam logic [ByteWidth-1:0] GfReduce = 8'h1b;

   // shared unit operation codes
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_WORD = 2'd1,
      OP_SCALE = 2'd2
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } mul_ctrl_type;

   function automatic logic [ByteWidth-1:0] gf_mul(input logic [ByteWidth-1:0] a,
                                                   input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] acc;
      logic [ByteWidth-1:0] sh;
      acc = '0;
      sh = a;
      for (int n = 0; n < ByteWidth; n++) begin
         if (b[n]) acc = acc ^ sh;
         sh = sh[ByteWidth-1] ? ({sh[ByteWidth-2:0], 1'b0} ^ GfReduce)
                              : {sh[ByteWidth-2:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

/* hw/rtl/word_inverse_mod_x4_plus_1_core.sv */
// inverse of a four-coefficient gf(2^8) polynomial modulo x^4+1
// req_ channel: req_poly_word, byte k is the coefficient of x^k
// rsp_ channel: rsp_inverse_word and rsp_has_inverse, one result per item
// the word is invertible exactly when the xor of its bytes is nonzero;
// the inverse is a^3 scaled by c^-4, with c^-1 computed as c^254
// all products run on one shared four-lane multiplier under a sequencer:
// byte and scale products are formed lane by lane at once, word products sum one
// byte of a per step as b rotates; each is issued, then waited on in ST_WAIT
// c^254 takes 14 squarings/products, then c^-2, c^-4, a^2, a^3 and the scale
// an invertible word runs all of these before the result is registered; a word
// with no inverse goes from the check state straight to the output register
// one item at a time: req_ready is low from transfer in until the result
// has been taken; a stalled rsp_ready holds the result in the output
// register and keeps the block busy
// reset (synchronous, active high) returns to idle and drops rsp_valid
module word_inverse_mod_x4_plus_1_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_poly_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_inverse_word,
   output logic        rsp_has_inverse
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_POW_SQ, ST_POW_MUL, ST_CI2, ST_CI4,
      ST_A2, ST_A3, ST_SCALE, ST_WAIT, ST_OUT
   } state_type;

   state_type   state_ff, state_in, after_ff, after_in;
   logic [31:0] a_ff, a_in;
   logic [7:0]  c_ff, c_in;
   logic [7:0]  r_ff, r_in;
   logic [31:0] w_ff, w_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        flag_ff, flag_in;
   logic        valid_ff, valid_in;
   logic [31:0] ma, mb, prod;
   logic        done;
   wim_pkg::mul_ctrl_type ctrl;

   wim_mul u_mul (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .a (ma), .b (mb), .prod (prod), .done (done)
   );

   // c^254 = product of c^(2^k) for k = 1..7; r holds result, c squares
   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      a_in = a_ff; c_in = c_ff; r_in = r_ff; w_in = w_ff;
      cnt_in = cnt_ff; flag_in = flag_ff; valid_in = valid_ff;
      ctrl.start = 1'b0;
      ctrl.op = wim_pkg::OP_BYTE;
      ma = '0; mb = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in = req_poly_word;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            c_in = a_ff[7:0] ^ a_ff[15:8] ^ a_ff[23:16] ^ a_ff[31:24];
            r_in = 8'h01;
            cnt_in = '0;
            if (c_in == 8'h00) begin
               flag_in = 1'b0; w_in = '0; valid_in = 1'b1; state_in = ST_OUT;
            end else begin
               flag_in = 1'b1; state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            ctrl.start = 1'b1; ma = {24'h0, c_ff}; mb = {24'h0, c_ff};
            after_in = ST_POW_MUL; state_in = ST_WAIT;
         end
         ST_POW_MUL: begin
            c_in = prod[7:0];
            ctrl.start = 1'b1; ma = {24'h0, r_ff}; mb = {24'h0, prod[7:0]};
            after_in = (cnt_ff == 3'd6) ? ST_CI2 : ST_POW_SQ;
            cnt_in = cnt_ff + 3'd1;
            state_in = ST_WAIT;
         end
         ST_CI2: begin
            ctrl.start = 1'b1; ma = prod; mb = prod;
            after_in = ST_CI4; state_in = ST_WAIT;
         end
         ST_CI4: begin
            ctrl.start = 1'b1; ma = prod; mb = prod;
            after_in = ST_A2; state_in = ST_WAIT;
         end
         ST_A2: begin
            c_in = prod[7:0];
            ctrl.start = 1'b1; ctrl.op = wim_pkg::OP_WORD; ma = a_ff; mb = a_ff;
            after_in = ST_A3; state_in = ST_WAIT;
         end
         ST_A3: begin
            ctrl.start = 1'b1; ctrl.op = wim_pkg::OP_WORD; ma = prod; mb = a_ff;
            after_in = ST_SCALE; state_in = ST_WAIT;
         end
         ST_SCALE: begin
            ctrl.start = 1'b1; ctrl.op = wim_pkg::OP_SCALE;
            ma = prod; mb = {24'h0, c_ff};
            after_in = ST_OUT; state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (done) begin
               if (after_ff == ST_POW_MUL) r_in = r_ff;
               if (after_ff == ST_POW_SQ || after_ff == ST_CI2) r_in = prod[7:0];
               if (after_ff == ST_OUT) begin
                  w_in = prod; valid_in = 1'b1;
               end
               state_in = after_ff;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               valid_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      a_ff <= a_in; c_ff <= c_in; r_ff <= r_in; w_ff <= w_in; flag_ff <= flag_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_inverse_word = w_ff;
   assign rsp_has_inverse = flag_ff;

endmodule

/* hw/rtl/wim_mul.sv */
// shared four-lane gf(2^8) multiplier; done is a registered flag raised when a product is finished
module wim_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  wim_pkg::mul_ctrl_type ctrl,
   input  logic [31:0]          a,
   input  logic [31:0]          b,
   output logic [31:0]          prod,
   output logic                 done
);

   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   wim_pkg::op_type op_ff, op_in;
   logic [31:0] lane;
   logic [7:0]  ai;

   // in word mode lane k multiplies a_i by b_(k-i); b rotates one byte a step
   always_comb begin
      ai = a_ff[8*step_ff +: 8];
      for (int k = 0; k < 4; k++) begin
         case (op_ff)
            wim_pkg::OP_WORD: lane[8*k +: 8] = wim_pkg::gf_mul(ai, b_ff[8*k +: 8]);
            wim_pkg::OP_SCALE: lane[8*k +: 8] = wim_pkg::gf_mul(a_ff[8*k +: 8], b_ff[7:0]);
            default: lane[8*k +: 8] = (k == 0) ? wim_pkg::gf_mul(a_ff[7:0], b_ff[7:0]) : 8'h00;
         endcase
      end
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      op_in   = op_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         op_in   = ctrl.op;
      end else if (busy_ff) begin
         acc_in = acc_ff ^ lane;
         if (op_ff == wim_pkg::OP_WORD && step_ff != 2'd3) begin
            step_in = step_ff + 2'd1;
            b_in = {b_ff[23:0], b_ff[31:24]};
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         op_ff   <= wim_pkg::OP_BYTE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

/* hw/rtl/wim_checker.sv */
`include "assert_macros.svh"

module wim_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_inverse_word,
   input logic        rsp_has_inverse
);

   `CHK_IMPLY(no_inv_zero, clock, reset, rsp_valid && !rsp_has_inverse, rsp_inverse_word == 32'h0)
   `CHK_IMPLY(busy_while_out, clock, reset, rsp_valid, !req_ready)
   `CHK_NEXT(no_out_after_in, clock, reset, req_valid && req_ready, !rsp_valid)
   `CHK_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inverse_word))

endmodule

bind word_inverse_mod_x4_plus_1_core wim_checker u_wim_checker (
   .clock (clock), .reset (reset), .req_valid (req_valid), .req_ready (req_ready),
   .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
   .rsp_inverse_word (rsp_inverse_word), .rsp_has_inverse (rsp_has_inverse)
);
